>>> src/dtrq_pkg.sv
package dtrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int REL_W = $clog2(MAX_RESULTS + 1);

    localparam logic OP_SUBMIT    = 1'b0;
    localparam logic OP_TICK      = 1'b1;
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  task_tag;
        logic [15:0] delay_ticks;
    } dtrq_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] released_tag;
        logic       last_of_run;
    } dtrq_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN
    } dtrq_state_t;

    typedef struct packed {
        logic store;
        logic reject;
        logic tick;
        logic step;
        logic pick;
        logic finish;
    } dtrq_cmd_t;

    typedef struct packed {
        logic full;
        logic scan_done;
        logic found;
        logic rel_full;
    } dtrq_status_t;

endpackage

>>> src/dtrq_ctrl.sv
module dtrq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  opcode,
    input  dtrq_pkg::dtrq_status_t status,
    output dtrq_pkg::dtrq_cmd_t   cmd,
    output logic                  busy
);
    import dtrq_pkg::*;

    dtrq_state_t state_reg;
    dtrq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (opcode == OP_TICK)
                    begin
                        cmd.tick   = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else if (status.full)
                    begin
                        cmd.reject = 1'b1;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.rel_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!status.scan_done)
                begin
                    cmd.step = 1'b1;
                end
                else if (status.found)
                begin
                    // take the winner and rescan what is left
                    cmd.pick = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/dtrq_datapath.sv
module dtrq_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dtrq_pkg::dtrq_item_t   item,
    input  dtrq_pkg::dtrq_cmd_t    cmd,
    output dtrq_pkg::dtrq_status_t status,
    output dtrq_pkg::dtrq_result_t result,
    output logic                   result_strobe
);
    import dtrq_pkg::*;

    logic [31:0]      time_reg;
    logic [31:0]      deadline_reg [QUEUE_DEPTH];
    logic [7:0]       tag_reg [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_diff_reg;
    logic             held_valid_reg;
    logic [7:0]       held_tag_reg;
    logic [REL_W-1:0] rel_cnt_reg;
    dtrq_result_t     result_reg;
    logic             strobe_reg;

    logic [IDX_W-1:0] scan_idx;
    logic [31:0]      diff;
    logic             better;

    assign scan_idx = scan_idx_reg[IDX_W-1:0];
    // wrap-safe: due when deadline - now is negative
    assign diff     = deadline_reg[scan_idx] - time_reg;
    assign better   = diff[31] && (!found_reg || (diff < best_diff_reg));

    assign status.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.scan_done = (scan_idx_reg >= count_reg);
    assign status.found     = found_reg;
    assign status.rel_full  = (rel_cnt_reg == REL_W'(MAX_RESULTS));

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            rel_cnt_reg    <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            // a pick or finish sends out the release held from the previous scan
            strobe_reg <= cmd.reject || ((cmd.pick || cmd.finish) && held_valid_reg);
            if (cmd.store)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.tick)
            begin
                time_reg       <= time_reg + 32'd1;
                scan_idx_reg   <= '0;
                found_reg      <= 1'b0;
                held_valid_reg <= 1'b0;
                rel_cnt_reg    <= '0;
            end
            if (cmd.step)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.pick)
            begin
                count_reg      <= count_reg - CNT_W'(1);
                scan_idx_reg   <= '0;
                found_reg      <= 1'b0;
                held_valid_reg <= 1'b1;
                rel_cnt_reg    <= rel_cnt_reg + REL_W'(1);
            end
            if (cmd.finish)
            begin
                held_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            deadline_reg[count_reg[IDX_W-1:0]] <= time_reg + 32'(item.delay_ticks);
            tag_reg[count_reg[IDX_W-1:0]]      <= item.task_tag;
        end
        if (cmd.pick)
        begin
            // close the gap left by the released entry
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (IDX_W'(i) >= best_idx_reg)
                begin
                    deadline_reg[i] <= deadline_reg[i + 1];
                    tag_reg[i]      <= tag_reg[i + 1];
                end
            end
            held_tag_reg <= tag_reg[best_idx_reg];
        end
        if (cmd.step && better)
        begin
            best_idx_reg  <= scan_idx;
            best_diff_reg <= diff;
        end
        if (cmd.reject)
        begin
            result_reg.kind         <= KIND_REJECT;
            result_reg.released_tag <= item.task_tag;
            result_reg.last_of_run  <= 1'b1;
        end
        if (cmd.pick || cmd.finish)
        begin
            result_reg.kind         <= KIND_RELEASE;
            result_reg.released_tag <= held_tag_reg;
            result_reg.last_of_run  <= cmd.finish;
        end
    end

endmodule

>>> src/deadline_task_release_queue_unit.sv
// Deadline task release queue. A submit beat stores a task with deadline now + delay_ticks;
// it gives no result, or one reject result (kind 1, last_of_run 1) on
// the next cycle when the store is full. A tick beat advances time by one and then releases
// every due task, earliest deadline first, equal deadlines in submit order, one result per
// strobe, last_of_run set on the final one; busy stays high until the final release has
// been found, and that last result comes out in the first cycle with busy low.
// Each release needs one linear scan of the stored entries, one entry per cycle through a
// single 32-bit subtract/compare; the tick ends with a scan that finds nothing due, or
// once MAX_RESULTS releases have been picked. result_strobe is high for one cycle per
// result and cannot be held off.
module deadline_task_release_queue_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  dtrq_pkg::dtrq_item_t   item,
    output dtrq_pkg::dtrq_result_t result,
    output logic                   result_strobe
);
    import dtrq_pkg::*;

    dtrq_cmd_t    cmd;
    dtrq_status_t status;

    dtrq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    dtrq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .status        (status),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

>>> tb/deadline_task_release_queue_unit_tb.sv
module deadline_task_release_queue_unit_tb;
    import dtrq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_BEATS = 250;
    localparam int QUIET_TAIL   = 40;

    typedef struct {
        dtrq_item_t   beat;
        bit           typed;
        int           n_typed;
        dtrq_result_t typed_res;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic         result_strobe;
    dtrq_item_t   item;
    dtrq_result_t result;

    // shadow of the task store, kept in submit order
    logic [31:0]  now_ticks;
    logic [31:0]  task_deadline[$];
    logic [7:0]   task_tag_q[$];
    dtrq_result_t release_batch[$];
    dtrq_result_t due_results[$];
    dir_row_t     rows[$];

    bit           beat_taken;
    bit           row_typed;
    int           row_n;
    dtrq_result_t row_res;
    int           errors = 0;
    int           cycles = 0;

    deadline_task_release_queue_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result        (result),
        .result_strobe (result_strobe)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic predict_release(input dtrq_item_t b);
        int          best;
        logic [31:0] best_diff;
        logic [31:0] diff;
        int          n;
        release_batch.delete();
        if (b.opcode == OP_SUBMIT)
        begin
            if (task_tag_q.size() >= QUEUE_DEPTH)
                release_batch.insert(release_batch.size(),
                                     dtrq_result_t'({KIND_REJECT, b.task_tag, 1'b1}));
            else
            begin
                task_deadline.insert(task_deadline.size(), now_ticks + 32'(b.delay_ticks));
                task_tag_q.insert(task_tag_q.size(), b.task_tag);
            end
        end
        else
        begin
            now_ticks = now_ticks + 32'd1;
            for (n = 0; n < MAX_RESULTS; n++)
            begin
                best      = -1;
                best_diff = '0;
                // due when deadline - now is negative; strict < keeps submit order on ties
                foreach (task_deadline[i])
                begin
                    diff = task_deadline[i] - now_ticks;
                    if (diff[31] && (best < 0 || diff < best_diff))
                    begin
                        best      = i;
                        best_diff = diff;
                    end
                end
                if (best < 0)
                    break;
                release_batch.insert(release_batch.size(),
                                     dtrq_result_t'({KIND_RELEASE, task_tag_q[best], 1'b0}));
                task_deadline.delete(best);
                task_tag_q.delete(best);
            end
            if (release_batch.size() > 0)
                release_batch[release_batch.size() - 1].last_of_run = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        dtrq_result_t want;
        if (!rst_n)
            beat_taken <= 1'b0;
        else
        begin
            beat_taken <= start && !busy;
            if (start && !busy)
            begin
                predict_release(item);
                if (row_typed)
                begin
                    for (int i = 0; i < row_n; i++)
                        due_results.insert(due_results.size(), row_res);
                end
                else
                begin
                    foreach (release_batch[i])
                        due_results.insert(due_results.size(), release_batch[i]);
                end
            end
            if (result_strobe)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: kind %0d tag %02h last %0d", $time,
                             result.kind, result.released_tag, result.last_of_run);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.kind !== want.kind || result.released_tag !== want.released_tag
                        || result.last_of_run !== want.last_of_run)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected kind %0d tag %02h last %0d,",
                                 $time, want.kind, want.released_tag, want.last_of_run,
                                 " got kind %0d tag %02h last %0d",
                                 result.kind, result.released_tag, result.last_of_run);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("deadline_task_release_queue_unit regression: fail");
            $finish;
        end
    end

    task automatic add_row(input logic op, input logic [7:0] tag, input logic [15:0] delay,
                           input bit typed, input int n, input dtrq_result_t res);
        dir_row_t r;
        r.beat.opcode      = op;
        r.beat.task_tag    = tag;
        r.beat.delay_ticks = delay;
        r.typed            = typed;
        r.n_typed          = n;
        r.typed_res        = res;
        rows.insert(rows.size(), r);
    endtask

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input dtrq_item_t b, input bit typed, input int n,
                             input dtrq_result_t res);
        start     <= 1'b1;
        item      <= b;
        row_typed <= typed;
        row_n     <= n;
        row_res   <= res;
        do
            @(negedge clk);
        while (!beat_taken);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic dtrq_item_t rand_beat();
        dtrq_item_t b;
        int         pick;
        int         submit_pct;
        // lean toward ticks once the store is nearly full
        submit_pct    = (task_tag_q.size() >= 12) ? 30 : 55;
        b.opcode      = ($urandom_range(0, 99) < submit_pct) ? OP_SUBMIT : OP_TICK;
        b.task_tag    = 8'($urandom_range(0, 255));
        pick          = $urandom_range(0, 99);
        if (pick < 70)
            b.delay_ticks = 16'($urandom_range(0, 15));
        else if (pick < 97)
            b.delay_ticks = 16'($urandom_range(0, 255));
        else
            b.delay_ticks = 16'($urandom_range(0, 65535));
        return b;
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        row_typed = 1'b0;
        row_n     = 0;
        row_res   = '0;
        now_ticks = '0;

        add_row(OP_TICK,   8'h00, 16'h0000, 1, 0, '0);    // nothing due after reset
        add_row(OP_SUBMIT, 8'h00, 16'h0000, 1, 0, '0);    // zero delay
        add_row(OP_TICK,   8'h00, 16'h0000, 1, 1, {KIND_RELEASE, 8'h00, 1'b1});
        add_row(OP_SUBMIT, 8'hFF, 16'hFFFF, 1, 0, '0);
        add_row(OP_SUBMIT, 8'h5A, 16'h0001, 1, 0, '0);
        add_row(OP_SUBMIT, 8'hA5, 16'h0001, 1, 0, '0);
        add_row(OP_SUBMIT, 8'h11, 16'h0000, 1, 0, '0);
        add_row(OP_TICK,   8'h00, 16'h0000, 1, 1, {KIND_RELEASE, 8'h11, 1'b1});
        add_row(OP_TICK,   8'h00, 16'h0000, 0, 0, '0);    // tied deadlines, submit order
        for (int i = 0; i < 15; i++)
            add_row(OP_SUBMIT, 8'(8'h20 + i), 16'h0000, 1, 0, '0);
        add_row(OP_SUBMIT, 8'hC3, 16'h1234, 1, 1, {KIND_REJECT, 8'hC3, 1'b1});  // store full
        add_row(OP_TICK,   8'h00, 16'h0000, 0, 0, '0);    // long release run

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            send_beat(rows[i].beat, rows[i].typed, rows[i].n_typed, rows[i].typed_res);
            if ($urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 11));
        end

        for (int k = 0; k < RANDOM_BEATS; k++)
        begin
            if (k == RANDOM_BEATS / 2)
            begin
                idle_for(1);
                while (due_results.size() != 0 || busy)
                    @(negedge clk);
            end
            send_beat(rand_beat(), 1'b0, 0, '0);
            if (k < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 11));
        end

        idle_for(1);
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("deadline_task_release_queue_unit regression: pass");
        else
            $display("deadline_task_release_queue_unit regression: fail");
        $finish;
    end

endmodule
